@@ hdl/sbcf_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcf_pkg: shared types, constants and frame templates
// Byte codes of the servo bus protocol, the lane and plan types, and the
// functions that lay out each frame kind as a list of tagged bytes.
// ----------------------------------------------------------------------------
package sbcf_pkg;

	// protocol bytes
	localparam logic [7:0] HEAD_BYTE      = 8'hFF;
	localparam logic [7:0] BROADCAST_ID   = 8'hFE;
	localparam logic [7:0] INST_WRITE     = 8'h03;
	localparam logic [7:0] INST_SYNC      = 8'h83;
	localparam logic [7:0] REG_MODE       = 8'h21;
	localparam logic [7:0] REG_GOAL_POS   = 8'h2A;
	localparam logic [7:0] REG_GOAL_SPEED = 8'h2E;
	localparam logic [7:0] MODE_POSITION  = 8'h00;
	localparam logic [7:0] MODE_SPEED     = 8'h01;
	localparam logic [7:0] SPEED_DLEN     = 8'h02;
	localparam logic [7:0] POS_DLEN       = 8'h06;

	// length byte = parameter count + 2
	localparam logic [7:0] LEN_MODE       = 8'd4;
	localparam logic [7:0] LEN_ROTOR      = 8'd5;
	localparam logic [7:0] LEN_SYNC_SPEED = 8'd13;
	localparam logic [7:0] LEN_SYNC_POS   = 8'd25;

	// bytes per frame kind
	localparam int MODE_BYTES  = 8;
	localparam int ROTOR_BYTES = 9;
	localparam int SSYNC_BYTES = 17;
	localparam int PSYNC_BYTES = 29;

	// longest command (stop all)
	localparam int BUF_LEN = 34;
	localparam int CNT_W   = $clog2(BUF_LEN + 1);

	// command opcodes
	localparam logic [2:0] OP_MODE_SPEED = 3'd0;
	localparam logic [2:0] OP_MODE_POS   = 3'd1;
	localparam logic [2:0] OP_SYNC_SPEED = 3'd2;
	localparam logic [2:0] OP_SYNC_POS   = 3'd3;
	localparam logic [2:0] OP_ROTOR      = 3'd4;
	localparam logic [2:0] OP_STOP       = 3'd5;

	// register indexes
	localparam logic [2:0] CFG_GROUP_FIRST  = 3'd0;
	localparam logic [2:0] CFG_GROUP_SECOND = 3'd1;
	localparam logic [2:0] CFG_GROUP_THIRD  = 3'd2;
	localparam logic [2:0] CFG_ROTOR_ID     = 3'd3;
	localparam logic [2:0] CFG_POS_FLOOR    = 3'd4;
	localparam logic [2:0] CFG_POS_CEILING  = 3'd5;
	localparam logic [2:0] CFG_SPEED_LIMIT  = 3'd6;

	// byte tag: header bytes stay out of the checksum, the checksum
	// byte is filled in by the serializer
	typedef enum logic [1:0] {
		K_HEAD,
		K_DATA,
		K_CKS
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] val;
	} ent_t;

	typedef ent_t [BUF_LEN-1:0] ent_buf_t;

	typedef struct packed {
		ent_buf_t        ents;
		logic [CNT_W-1:0] count;
	} plan_t;

	typedef struct packed {
		logic [7:0]  id_first;
		logic [7:0]  id_second;
		logic [7:0]  id_third;
		logic [7:0]  rotor_id;
		logic [15:0] pos_floor;
		logic [15:0] pos_ceiling;
		logic [14:0] speed_limit;
	} cfg_t;

	typedef struct packed {
		logic [15:0] speed_w;
		logic [15:0] pos_w;
	} lane_out_t;

	function automatic ent_t ent_h();
		ent_t e;
		e.kind = K_HEAD;
		e.val  = HEAD_BYTE;
		return e;
	endfunction

	function automatic ent_t ent_d(input logic [7:0] v);
		ent_t e;
		e.kind = K_DATA;
		e.val  = v;
		return e;
	endfunction

	function automatic ent_t ent_c();
		ent_t e;
		e.kind = K_CKS;
		e.val  = 8'h00;
		return e;
	endfunction

	// write of the mode register to one servo
	function automatic ent_t [MODE_BYTES-1:0] mode_frame(input logic [7:0] id,
			input logic [7:0] mode);
		ent_t [MODE_BYTES-1:0] r;
		r[0] = ent_h();
		r[1] = ent_h();
		r[2] = ent_d(id);
		r[3] = ent_d(LEN_MODE);
		r[4] = ent_d(INST_WRITE);
		r[5] = ent_d(REG_MODE);
		r[6] = ent_d(mode);
		r[7] = ent_c();
		return r;
	endfunction

	// goal speed write to the rotor
	function automatic ent_t [ROTOR_BYTES-1:0] rotor_frame(input logic [7:0] id,
			input logic [15:0] w);
		ent_t [ROTOR_BYTES-1:0] r;
		r[0] = ent_h();
		r[1] = ent_h();
		r[2] = ent_d(id);
		r[3] = ent_d(LEN_ROTOR);
		r[4] = ent_d(INST_WRITE);
		r[5] = ent_d(REG_GOAL_SPEED);
		r[6] = ent_d(w[7:0]);
		r[7] = ent_d(w[15:8]);
		r[8] = ent_c();
		return r;
	endfunction

	function automatic ent_t [SSYNC_BYTES-1:0] speed_sync_frame(input cfg_t cfg,
			input logic [15:0] w1, input logic [15:0] w2, input logic [15:0] w3);
		ent_t [SSYNC_BYTES-1:0] r;
		r[0]  = ent_h();
		r[1]  = ent_h();
		r[2]  = ent_d(BROADCAST_ID);
		r[3]  = ent_d(LEN_SYNC_SPEED);
		r[4]  = ent_d(INST_SYNC);
		r[5]  = ent_d(REG_GOAL_SPEED);
		r[6]  = ent_d(SPEED_DLEN);
		r[7]  = ent_d(cfg.id_first);
		r[8]  = ent_d(w1[7:0]);
		r[9]  = ent_d(w1[15:8]);
		r[10] = ent_d(cfg.id_second);
		r[11] = ent_d(w2[7:0]);
		r[12] = ent_d(w2[15:8]);
		r[13] = ent_d(cfg.id_third);
		r[14] = ent_d(w3[7:0]);
		r[15] = ent_d(w3[15:8]);
		r[16] = ent_c();
		return r;
	endfunction

	function automatic ent_t [PSYNC_BYTES-1:0] pos_sync_frame(input cfg_t cfg,
			input logic [15:0] p1, input logic [15:0] p2, input logic [15:0] p3,
			input logic [15:0] tm, input logic [15:0] sp);
		ent_t [PSYNC_BYTES-1:0] r;
		logic [2:0][7:0]  ids;
		logic [2:0][15:0] pw;
		ids = {cfg.id_third, cfg.id_second, cfg.id_first};
		pw  = {p3, p2, p1};
		r[0] = ent_h();
		r[1] = ent_h();
		r[2] = ent_d(BROADCAST_ID);
		r[3] = ent_d(LEN_SYNC_POS);
		r[4] = ent_d(INST_SYNC);
		r[5] = ent_d(REG_GOAL_POS);
		r[6] = ent_d(POS_DLEN);
		for (int i = 0; i < 3; i++) begin
			r[7 + i*7]     = ent_d(ids[i]);
			r[7 + i*7 + 1] = ent_d(pw[i][7:0]);
			r[7 + i*7 + 2] = ent_d(pw[i][15:8]);
			r[7 + i*7 + 3] = ent_d(tm[7:0]);
			r[7 + i*7 + 4] = ent_d(tm[15:8]);
			r[7 + i*7 + 5] = ent_d(sp[7:0]);
			r[7 + i*7 + 6] = ent_d(sp[15:8]);
		end
		r[28] = ent_c();
		return r;
	endfunction

endpackage

@@ hdl/sbcf_lane.sv @@
// ----------------------------------------------------------------------------
// sbcf_lane: per-servo value encoder
// Clamps one value to the position range and encodes it as a
// sign-magnitude speed word saturated to the speed limit.
// ----------------------------------------------------------------------------
module sbcf_lane
	import sbcf_pkg::*;
(
	input  logic [15:0] value,
	input  cfg_t        cfg,
	output lane_out_t   lane_out
);

	logic        neg;
	logic [16:0] mag;

	always_comb begin
		neg = value[15];
		// magnitude of a negative word is 2^16 - pattern (up to 32768)
		mag = neg ? (17'h10000 - {1'b0, value}) : {1'b0, value};
		if (mag > {2'b00, cfg.speed_limit}) begin
			lane_out.speed_w = {neg, cfg.speed_limit};
		end else begin
			lane_out.speed_w = {neg, mag[14:0]};
		end

		if ($signed(value) < $signed(cfg.pos_floor)) begin
			lane_out.pos_w = cfg.pos_floor;
		end else if ($signed(value) > $signed(cfg.pos_ceiling)) begin
			lane_out.pos_w = cfg.pos_ceiling;
		end else begin
			lane_out.pos_w = value;
		end
	end

endmodule

@@ hdl/sbcf_merge.sv @@
// ----------------------------------------------------------------------------
// sbcf_merge: frame planner
// Combines the lane results into the tagged byte list of one command.
// ----------------------------------------------------------------------------
module sbcf_merge
	import sbcf_pkg::*;
(
	input  logic [2:0]      opcode,
	input  logic [15:0]     move_time,
	input  logic [15:0]     move_speed,
	input  cfg_t            cfg,
	input  lane_out_t [2:0] lanes,
	output plan_t           plan
);

	logic [15:0] sp_sat;

	always_comb begin
		if (move_speed > {1'b0, cfg.speed_limit}) begin
			sp_sat = {1'b0, cfg.speed_limit};
		end else begin
			sp_sat = move_speed;
		end
	end

	always_comb begin
		plan.ents  = '0;
		plan.count = '0;
		case (opcode)
			OP_MODE_SPEED: begin
				plan.ents[3*MODE_BYTES-1:0] = {mode_frame(cfg.id_third, MODE_SPEED),
					mode_frame(cfg.id_second, MODE_SPEED),
					mode_frame(cfg.id_first, MODE_SPEED)};
				plan.count = CNT_W'(3*MODE_BYTES);
			end
			OP_MODE_POS: begin
				plan.ents[3*MODE_BYTES-1:0] = {mode_frame(cfg.id_third, MODE_POSITION),
					mode_frame(cfg.id_second, MODE_POSITION),
					mode_frame(cfg.id_first, MODE_POSITION)};
				plan.count = CNT_W'(3*MODE_BYTES);
			end
			OP_SYNC_SPEED: begin
				plan.ents[SSYNC_BYTES-1:0] = speed_sync_frame(cfg, lanes[0].speed_w,
					lanes[1].speed_w, lanes[2].speed_w);
				plan.count = CNT_W'(SSYNC_BYTES);
			end
			OP_SYNC_POS: begin
				plan.ents[PSYNC_BYTES-1:0] = pos_sync_frame(cfg, lanes[0].pos_w,
					lanes[1].pos_w, lanes[2].pos_w, move_time, sp_sat);
				plan.count = CNT_W'(PSYNC_BYTES);
			end
			OP_ROTOR: begin
				plan.ents[MODE_BYTES+ROTOR_BYTES-1:0] = {
					rotor_frame(cfg.rotor_id, lanes[0].speed_w),
					mode_frame(cfg.rotor_id, MODE_SPEED)};
				plan.count = CNT_W'(MODE_BYTES + ROTOR_BYTES);
			end
			OP_STOP: begin
				// zero speed encodes as zero whatever the limit
				plan.ents[BUF_LEN-1:0] = {rotor_frame(cfg.rotor_id, 16'h0000),
					mode_frame(cfg.rotor_id, MODE_SPEED),
					speed_sync_frame(cfg, 16'h0000, 16'h0000, 16'h0000)};
				plan.count = CNT_W'(BUF_LEN);
			end
			default: begin
				plan.count = '0;
			end
		endcase
	end

endmodule

@@ hdl/sbcf_serial.sv @@
// ----------------------------------------------------------------------------
// sbcf_serial: byte serializer
// Shift line of tagged bytes, one byte out per request, running checksum.
// ----------------------------------------------------------------------------
module sbcf_serial
	import sbcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        plan_valid,
	input  plan_t       plan,
	output logic        plan_ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic [0:0]  m_tuser
);

	ent_buf_t         ents_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic             take;
	logic             load;

	assign take       = m_tvalid && m_tready;
	assign plan_ready = (count_q == '0) || ((count_q == CNT_W'(1)) && m_tready);
	assign load       = plan_valid && plan_ready;

	assign m_tvalid   = (count_q != '0);
	assign m_tlast    = (count_q == CNT_W'(1));
	assign m_tuser[0] = (ents_q[0].kind == K_CKS);
	assign m_tdata    = (ents_q[0].kind == K_CKS) ? ~sum_q : ents_q[0].val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			if (load) begin
				count_q <= plan.count;
			end else if (take) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (take) begin
				case (ents_q[0].kind)
					K_DATA:  sum_q <= sum_q + ents_q[0].val;
					K_CKS:   sum_q <= '0;
					default: sum_q <= sum_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ents_q <= plan.ents;
		end else if (take) begin
			ents_q <= {ent_t'('0), ents_q[BUF_LEN-1:1]};
		end
	end

endmodule

@@ hdl/servo_bus_command_framer_top.sv @@
// ----------------------------------------------------------------------------
// servo_bus_command_framer_top: servo bus command framer
// Turns one servo command into the byte stream of its bus frames.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one command request: opcode on s_tuser, the three
//    values, move time and move speed on s_tdata.
//  - Master stream emits one frame byte per request on m_tdata; m_tuser marks
//    the checksum byte of each frame, m_tlast the final byte of the command.
//  - Config channel writes one register per request (cfg_index, cfg_data);
//    cfg_ready is always high; write only while the block is idle.
//  - Path: with the byte side idle, a taken command goes through the input
//    register, then into the byte shift line, where its first byte is valid.
//  - Throughput: one byte per cycle while the receiver is ready; a command has
//    17 to 34 bytes. The next command is planned while the current one drains,
//    so frames run back to back. Opcodes 6 and 7 are taken and emit nothing.
//  - Reset clears all pending work and restores the register defaults.
//  - A receiver stall holds the current byte; the held command then blocks
//    further command requests.
// ----------------------------------------------------------------------------
module servo_bus_command_framer_top
	import sbcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // value_a, value_b, value_c, move_time, move_speed
	input  logic [2:0]  s_tuser,   // opcode
	// byte out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // tx_byte
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // frame_end
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t              cfg_q;

	// stage 1: accepted command
	logic              valid_s1;
	logic [2:0]        opcode_s1;
	logic [2:0][15:0]  value_s1;
	logic [15:0]       time_s1;
	logic [15:0]       speed_s1;

	lane_out_t [2:0]   lanes;
	plan_t             plan;
	logic              plan_ready;
	logic              load;

	assign cfg_ready = 1'b1;
	assign load      = valid_s1 && plan_ready;
	assign s_tready  = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.id_first    <= 8'd1;
			cfg_q.id_second   <= 8'd2;
			cfg_q.id_third    <= 8'd3;
			cfg_q.rotor_id    <= 8'd4;
			cfg_q.pos_floor   <= 16'd0;
			cfg_q.pos_ceiling <= 16'd4095;
			cfg_q.speed_limit <= 15'd3400;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GROUP_FIRST:  cfg_q.id_first    <= cfg_data[7:0];
				CFG_GROUP_SECOND: cfg_q.id_second   <= cfg_data[7:0];
				CFG_GROUP_THIRD:  cfg_q.id_third    <= cfg_data[7:0];
				CFG_ROTOR_ID:     cfg_q.rotor_id    <= cfg_data[7:0];
				CFG_POS_FLOOR:    cfg_q.pos_floor   <= cfg_data;
				CFG_POS_CEILING:  cfg_q.pos_ceiling <= cfg_data;
				CFG_SPEED_LIMIT:  cfg_q.speed_limit <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// command holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1   <= s_tuser;
			value_s1[0] <= s_tdata[15:0];
			value_s1[1] <= s_tdata[31:16];
			value_s1[2] <= s_tdata[47:32];
			time_s1     <= s_tdata[63:48];
			speed_s1    <= s_tdata[79:64];
		end
	end

	// one encoder per servo value
	for (genvar g = 0; g < 3; g++) begin : g_lane
		sbcf_lane u_lane (
			.value    (value_s1[g]),
			.cfg      (cfg_q),
			.lane_out (lanes[g])
		);
	end

	sbcf_merge u_merge (
		.opcode     (opcode_s1),
		.move_time  (time_s1),
		.move_speed (speed_s1),
		.cfg        (cfg_q),
		.lanes      (lanes),
		.plan       (plan)
	);

	sbcf_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (valid_s1),
		.plan       (plan),
		.plan_ready (plan_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
